### rtl/mme_pkg.sv
// ----------------------------------------------------------------------------
// mme_pkg
// Shared sizes, opcodes and the state update record of the execute unit.
// ----------------------------------------------------------------------------
package mme_pkg;

  localparam int REG_COUNT  = 8;
  // The data memory depth must be a power of two.
  localparam int MEM_DEPTH  = 16;
  localparam int REG_IDX_W  = $clog2(REG_COUNT);
  localparam int MEM_ADDR_W = $clog2(MEM_DEPTH);
  localparam int DATA_W     = 8;
  localparam int FIELD_W    = 4;

  localparam logic [FIELD_W-1:0] RESET_REG_SEL = 4'd6;
  localparam logic [DATA_W-1:0]  RESET_REG_VAL = 8'h0F;

  typedef enum logic [3:0] {
    OP_SUB  = 4'd0,
    OP_SW   = 4'd1,
    OP_SLL  = 4'd2,
    OP_SRL  = 4'd3,
    OP_LW   = 4'd4,
    OP_ORI  = 4'd5,
    OP_BNEQ = 4'd6,
    OP_AND  = 4'd7,
    OP_ADDI = 4'd8,
    OP_NOR  = 4'd9,
    OP_ANDI = 4'd10,
    OP_OR   = 4'd11,
    OP_SUBI = 4'd12,
    OP_BEQ  = 4'd13,
    OP_ADD  = 4'd14,
    OP_JUMP = 4'd15
  } op_t;

  typedef struct packed {
    logic                  reg_we;
    logic [REG_IDX_W-1:0]  reg_idx;
    logic [DATA_W-1:0]     reg_data;
    logic                  mem_we;
    logic [MEM_ADDR_W-1:0] mem_addr;
    logic [DATA_W-1:0]     mem_data;
  } wr_t;

  // A field is below twice REG_COUNT, so one compare and subtract wraps it.
  function automatic logic [REG_IDX_W-1:0] reg_index(input logic [FIELD_W-1:0] f);
    logic [FIELD_W:0] ext;
    logic [FIELD_W:0] cnt;
    logic [FIELD_W:0] res;
    ext = {1'b0, f};
    cnt = (FIELD_W+1)'(REG_COUNT);
    res = (ext >= cnt) ? (ext - cnt) : ext;
    return res[REG_IDX_W-1:0];
  endfunction

endpackage

### rtl/mme_state.sv
// ----------------------------------------------------------------------------
// mme_state
// Register file and data memory, both in flops with their reset contents.
// ----------------------------------------------------------------------------
module mme_state
  import mme_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic [REG_IDX_W-1:0]  rd0_idx,
  input  logic [REG_IDX_W-1:0]  rd1_idx,
  input  logic [MEM_ADDR_W-1:0] mem_raddr,
  input  wr_t                   wr,
  output logic [DATA_W-1:0]     rd0_data,
  output logic [DATA_W-1:0]     rd1_data,
  output logic [DATA_W-1:0]     mem_rdata
);

  logic [DATA_W-1:0] regs [REG_COUNT];
  logic [DATA_W-1:0] mem  [MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        regs[i] <= '0;
      end
      regs[reg_index(RESET_REG_SEL)] <= RESET_REG_VAL;
      for (int j = 0; j < MEM_DEPTH; j++) begin
        mem[j] <= '0;
      end
    end else begin
      if (wr.reg_we) begin
        regs[wr.reg_idx] <= wr.reg_data;
      end
      if (wr.mem_we) begin
        mem[wr.mem_addr] <= wr.mem_data;
      end
    end
  end

  assign rd0_data  = regs[rd0_idx];
  assign rd1_data  = regs[rd1_idx];
  assign mem_rdata = mem[mem_raddr];

endmodule

### rtl/mme_alu.sv
// ----------------------------------------------------------------------------
// mme_alu
// Decodes one instruction and forms the state update and the zero flag.
// ----------------------------------------------------------------------------
module mme_alu
  import mme_pkg::*;
(
  input  logic                  exec,
  input  logic [15:0]           instruction,
  input  logic [DATA_W-1:0]     rh,
  input  logic [DATA_W-1:0]     ra,
  input  logic [DATA_W-1:0]     mem_rdata,
  output logic [MEM_ADDR_W-1:0] mem_addr,
  output wr_t                   wr,
  output logic                  zero_flag
);

  op_t               op;
  logic [FIELD_W-1:0] fa;
  logic [FIELD_W-1:0] fb;
  logic [DATA_W-1:0] bx;
  logic [DATA_W:0]   addr_sum;
  logic [DATA_W-1:0] value;
  logic              use_b;
  logic              writes;
  logic              cmp;

  assign op       = op_t'(instruction[15:12]);
  assign fa       = instruction[7:4];
  assign fb       = instruction[3:0];
  assign bx       = {{(DATA_W-FIELD_W){1'b0}}, fb};
  assign addr_sum = {1'b0, rh} + {1'b0, bx};
  assign mem_addr = addr_sum[MEM_ADDR_W-1:0];

  always_comb begin
    value  = '0;
    use_b  = 1'b0;
    writes = 1'b1;
    cmp    = 1'b0;
    case (op)
      OP_SUB:  begin value = rh - ra; use_b = 1'b1; end
      OP_SW:   writes = 1'b0;
      OP_SLL:  value = (fb[3]) ? '0 : (rh << fb[2:0]);
      OP_SRL:  value = (fb[3]) ? '0 : (rh >> fb[2:0]);
      OP_LW:   value = mem_rdata;
      OP_ORI:  value = rh | bx;
      OP_AND:  begin value = ra & rh; use_b = 1'b1; end
      OP_ADDI: value = rh + bx;
      OP_NOR:  begin value = ~(ra | rh); use_b = 1'b1; end
      OP_ANDI: value = rh & bx;
      OP_OR:   begin value = ra | rh; use_b = 1'b1; end
      OP_SUBI: value = rh - bx;
      OP_ADD:  begin value = ra + rh; use_b = 1'b1; end
      OP_BNEQ, OP_BEQ: begin writes = 1'b0; cmp = 1'b1; end
      default: writes = 1'b0;
    endcase
  end

  always_comb begin
    wr.reg_we   = exec && writes;
    wr.reg_idx  = reg_index(use_b ? fb : fa);
    wr.reg_data = value;
    wr.mem_we   = exec && (op == OP_SW);
    wr.mem_addr = mem_addr;
    wr.mem_data = ra;
  end

  assign zero_flag = writes ? (value == '0) : (cmp && (rh == ra));

endmodule

### rtl/mini_mips_execute_unit.sv
// ----------------------------------------------------------------------------
// mini_mips_execute_unit
// Eight-bit MIPS subset datapath: executes one 16-bit instruction, or reads
// the low nibble of a register, for each input item.
// ----------------------------------------------------------------------------
// Usage:
// An input item (action, instruction, read_address) is taken on an edge where
// in_valid is high and in_stall is low. It lands in an input register and is
// executed against the register file and data memory when it moves to the
// output register; the state is updated on that edge. The result item
// (zero_flag, read_nibble) then sits in the output register with out_valid
// high until an edge with out_stall low takes it.
// The item passes the input register and then the output register, so the
// edge that takes an item cannot also take its result. The unit takes one
// item every cycle while the receiver does not stall, since each item reads
// and writes the state in a single pass.
// When the receiver stalls, the output register holds its item, the input
// register fills, and in_stall rises until the output drains.
// Reset clears both valid flags, zeroes the data memory and the register file
// and loads register six with 0x0F; any item held in the unit is lost by it.
// ----------------------------------------------------------------------------
module mini_mips_execute_unit
  import mme_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [15:0] instruction,
  input  logic [3:0]  read_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        zero_flag,
  output logic [3:0]  read_nibble
);

  logic        s1_valid;
  logic        s1_action;
  logic [15:0] s1_instr;
  logic [3:0]  s1_raddr;
  logic        advance;
  logic        take_in;

  logic [REG_IDX_W-1:0]  rd0_idx;
  logic [REG_IDX_W-1:0]  rd1_idx;
  logic [DATA_W-1:0]     rd0_data;
  logic [DATA_W-1:0]     rd1_data;
  logic [DATA_W-1:0]     mem_rdata;
  logic [MEM_ADDR_W-1:0] mem_addr;
  wr_t                   wr;
  logic                  alu_zf;

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign take_in  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= take_in || (s1_valid && !advance);
    end
    if (take_in) begin
      s1_action <= action;
      s1_instr  <= instruction;
      s1_raddr  <= read_address;
    end
  end

  assign rd0_idx = reg_index(s1_action ? s1_raddr : s1_instr[11:8]);
  assign rd1_idx = reg_index(s1_instr[7:4]);

  mme_state u_state (
    .clk       (clk),
    .rst       (rst),
    .rd0_idx   (rd0_idx),
    .rd1_idx   (rd1_idx),
    .mem_raddr (mem_addr),
    .wr        (wr),
    .rd0_data  (rd0_data),
    .rd1_data  (rd1_data),
    .mem_rdata (mem_rdata)
  );

  mme_alu u_alu (
    .exec        (advance && !s1_action),
    .instruction (s1_instr),
    .rh          (rd0_data),
    .ra          (rd1_data),
    .mem_rdata   (mem_rdata),
    .mem_addr    (mem_addr),
    .wr          (wr),
    .zero_flag   (alu_zf)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      zero_flag   <= s1_action ? 1'b0 : alu_zf;
      read_nibble <= s1_action ? rd0_data[3:0] : 4'd0;
    end
  end

`ifndef SYNTHESIS
  a_state_only_on_exec: assert property (@(posedge clk) disable iff (rst)
    (wr.reg_we || wr.mem_we) |-> (advance && !s1_action))
    else $error("state written without an executed instruction");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled with room downstream");

  a_result_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(zero_flag && (read_nibble != 4'd0)))
    else $error("result carries both flag and nibble");

  a_no_result_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present right after reset");
`endif

endmodule
